// ===== sv/itr_pkg.sv =====
// Shared types, constants and the denomination lookup for the Roman numeral encoder.
package itr_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 7;

    localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic emit_last;
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] amount;
        logic [SYM_W-1:0]   first;
        logic [SYM_W-1:0]   second;
    } t_denom;

    // Greedy subtraction always takes the largest denomination not above a nonzero value.
    function automatic t_denom denom_lookup(input logic [VALUE_W-1:0] v);
        t_denom d;
        d.second = SYM_NONE;
        if (v >= VALUE_W'(1000)) begin
            d.amount = VALUE_W'(1000); d.first = SYM_M;
        end else if (v >= VALUE_W'(900)) begin
            d.amount = VALUE_W'(900);  d.first = SYM_C; d.second = SYM_M;
        end else if (v >= VALUE_W'(500)) begin
            d.amount = VALUE_W'(500);  d.first = SYM_D;
        end else if (v >= VALUE_W'(400)) begin
            d.amount = VALUE_W'(400);  d.first = SYM_C; d.second = SYM_D;
        end else if (v >= VALUE_W'(100)) begin
            d.amount = VALUE_W'(100);  d.first = SYM_C;
        end else if (v >= VALUE_W'(90)) begin
            d.amount = VALUE_W'(90);   d.first = SYM_X; d.second = SYM_C;
        end else if (v >= VALUE_W'(50)) begin
            d.amount = VALUE_W'(50);   d.first = SYM_L;
        end else if (v >= VALUE_W'(40)) begin
            d.amount = VALUE_W'(40);   d.first = SYM_X; d.second = SYM_L;
        end else if (v >= VALUE_W'(10)) begin
            d.amount = VALUE_W'(10);   d.first = SYM_X;
        end else if (v >= VALUE_W'(9)) begin
            d.amount = VALUE_W'(9);    d.first = SYM_I; d.second = SYM_X;
        end else if (v >= VALUE_W'(5)) begin
            d.amount = VALUE_W'(5);    d.first = SYM_V;
        end else if (v >= VALUE_W'(4)) begin
            d.amount = VALUE_W'(4);    d.first = SYM_I; d.second = SYM_V;
        end else begin
            d.amount = VALUE_W'(1);    d.first = SYM_I;
        end
        return d;
    endfunction

endpackage

// ===== sv/integer_to_roman_encoder_core.sv =====
// Top level of the integer to Roman numeral encoder.
// Each 12-bit value is emitted as its Roman numeral, one ASCII character per output
// transfer in reading order, with o_last on the final character; zero gives a single
// transfer with o_symbol zero and o_empty_res set. The value is loaded first, then the
// denomination selector and subtractor produce one character per cycle when the output
// is not stalled. A new value is taken once the last character of the previous one is
// in the output register.
module integer_to_roman_encoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [itr_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [itr_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last,
    output logic                        o_empty_res
);
    import itr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    itr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    itr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

endmodule

// ===== sv/itr_ctrl.sv =====
// Controller state machine that sequences loading and character emission.
module itr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  itr_pkg::t_status i_status,
    output itr_pkg::t_cmd   o_cmd
);
    import itr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_status.out_busy) begin
                    o_cmd.step = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/itr_datapath.sv =====
// Datapath holding the remaining value, the pair phase and the output register.
module itr_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itr_pkg::t_cmd               i_cmd,
    output itr_pkg::t_status            o_status,
    input  logic [itr_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [itr_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last,
    output logic                        o_empty_res
);
    import itr_pkg::*;

    logic [VALUE_W-1:0] r_value;
    logic               r_second;
    logic               r_zero;
    logic               r_out_valid;
    logic [SYM_W-1:0]   r_symbol;
    logic               r_last;
    logic               r_empty;

    t_denom             w_denom;
    logic               w_pair;
    logic               w_first_half;
    logic [VALUE_W-1:0] w_rest;
    logic [SYM_W-1:0]   w_sym;
    logic               w_last;

    always_comb begin
        w_denom      = denom_lookup(r_value);
        w_pair       = (w_denom.second != SYM_NONE);
        w_first_half = w_pair && !r_second;
        w_rest       = r_value - w_denom.amount;
        if (r_zero) begin
            w_sym  = SYM_NONE;
            w_last = 1'b1;
        end else if (w_first_half) begin
            w_sym  = w_denom.first;
            w_last = 1'b0;
        end else begin
            w_sym  = w_pair ? w_denom.second : w_denom.first;
            w_last = (w_rest == '0);
        end
    end

    assign o_status.out_busy  = r_out_valid && !i_out_ready;
    assign o_status.emit_last = w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value  <= i_value;
            r_zero   <= (i_value == '0);
            r_second <= 1'b0;
        end else if (i_cmd.step && !r_zero) begin
            if (w_first_half) begin
                r_second <= 1'b1;
            end else begin
                r_second <= 1'b0;
                r_value  <= w_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_symbol <= w_sym;
            r_last   <= w_last;
            r_empty  <= r_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule

// ===== tb/tb_integer_to_roman_encoder_core.sv =====
// Self-checking testbench that predicts each Roman numeral character and checks every transfer.
module tb_integer_to_roman_encoder_core;
    import itr_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [SYM_W-1:0]   symbol;
        logic               last;
        logic               empty;
    } t_numeral_char;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [VALUE_W-1:0] i_value     = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [SYM_W-1:0]   o_symbol;
    logic               o_last;
    logic               o_empty_res;

    int unsigned      denom_amount [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    logic [SYM_W-1:0] denom_first  [13] = '{SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
                                            SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I};
    logic [SYM_W-1:0] denom_second [13] = '{SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C,
                                            SYM_NONE, SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V,
                                            SYM_NONE};

    t_numeral_char pending_chars[$];
    int            mismatch_count = 0;
    int            gap_pct        = 0;
    int            stall_pct      = 0;

    integer_to_roman_encoder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Greedy subtraction over the denominations, appending the expected characters.
    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        t_numeral_char chars[$];
        t_numeral_char c;
        int unsigned   rest;
        c.value  = v;
        c.last   = 1'b0;
        c.empty  = 1'b0;
        rest     = 32'(v);
        if (v == '0) begin
            c.symbol = SYM_NONE;
            c.empty  = 1'b1;
            chars    = {chars, c};
        end
        for (int i = 0; i < 13; i++) begin
            while (rest >= denom_amount[i]) begin
                c.symbol = denom_first[i];
                chars    = {chars, c};
                if (denom_second[i] != SYM_NONE) begin
                    c.symbol = denom_second[i];
                    chars    = {chars, c};
                end
                rest -= denom_amount[i];
            end
        end
        for (int j = 0; j < chars.size(); j++) begin
            c = chars[j];
            c.last = (j == chars.size() - 1);
            pending_chars = {pending_chars, c};
        end
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        predict_numeral(v);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_numeral_char exp_c;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected transfer sym=%h last=%b empty=%b",
                             o_symbol, o_last, o_empty_res);
            end else begin
                exp_c = pending_chars.pop_front();
                if (o_symbol !== exp_c.symbol || o_last !== exp_c.last ||
                        o_empty_res !== exp_c.empty) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display(
                            "ERROR: value %0d expected sym=%h last=%b empty=%b, %s",
                            exp_c.value, exp_c.symbol, exp_c.last, exp_c.empty,
                            $sformatf("got sym=%h last=%b empty=%b",
                                      o_symbol, o_last, o_empty_res));
                end
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VALUE_W'(4000 + $urandom_range(95));
            2:       return VALUE_W'($urandom_range(3) * 1000 + ($urandom_range(1) ? 888 : 388));
            default: return VALUE_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic test_extremes();
        logic [VALUE_W-1:0] vals[$];
        gap_pct   = 0;
        stall_pct = 0;
        vals = '{0, 1, 3, 3888, 3999, 4000, 4095, 2730, 1365, 2048};
        foreach (vals[i]) send_value(vals[i]);
        wait_drained();
    endtask

    task automatic test_subtractive_pairs();
        logic [VALUE_W-1:0] vals[$];
        gap_pct   = 24;
        stall_pct = 24;
        vals = '{4, 5, 9, 10, 40, 50, 90, 100, 400, 500, 900, 1000, 1994, 444};
        foreach (vals[i]) send_value(vals[i]);
        wait_drained();
    endtask

    task automatic test_random_phase(input int gap, input int stall, input int count);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) send_value(random_value());
        wait_drained();
    endtask

    // The sender holds off until the numerals already accepted have fully drained.
    task automatic test_drain_pause();
        gap_pct   = 0;
        stall_pct = 24;
        repeat (3) send_value(random_value());
        wait_drained();
        repeat (3) send_value(random_value());
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_subtractive_pairs();
        test_random_phase(0, 0, 18);
        test_random_phase(81, 0, 18);
        test_random_phase(0, 81, 18);
        test_random_phase(24, 24, 18);
        test_drain_pause();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
